>>> design/lfia_pkg.sv
// Shared constants, result codes and controller/datapath interface types for the ID allocator.
package lfia_pkg;

  localparam int MAX_IDS   = 256;
  localparam int MAP_DEPTH = 256;
  localparam int ID_W      = 8;
  localparam int HW_W      = 9;
  localparam int GRP_N     = 16;
  localparam int GRP_W     = 4;
  localparam int BIT_N     = 16;
  localparam int BIT_W     = 4;

  localparam int ID_LIMIT_I = (MAX_IDS < MAP_DEPTH) ? MAX_IDS : MAP_DEPTH;
  localparam logic [HW_W-1:0] ID_LIMIT = HW_W'(ID_LIMIT_I);

  localparam logic [1:0] OUT_GRANTED   = 2'd0;
  localparam logic [1:0] OUT_RELEASED  = 2'd1;
  localparam logic [1:0] OUT_EXHAUSTED = 2'd2;
  localparam logic [1:0] OUT_INVALID   = 2'd3;

  localparam logic MODE_RELEASE = 1'b1;

  typedef struct packed {
    logic load;
    logic find_grp;
    logic alloc;
    logic release_chk;
    logic walk;
    logic push;
  } lfia_cmd_t;

  typedef struct packed {
    logic rel_top;
    logic walk_more;
  } lfia_sts_t;

endpackage

>>> design/lfia_ctrl.sv
// Controller state machine that sequences allocate, release, walk-down and result hand-off.
module lfia_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_mode,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output lfia_pkg::lfia_cmd_t cmd,
  input  lfia_pkg::lfia_sts_t sts
);
  import lfia_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GRP  = 3'd1;
  localparam logic [2:0] S_BIT  = 3'd2;
  localparam logic [2:0] S_REL  = 3'd3;
  localparam logic [2:0] S_WALK = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_mode == MODE_RELEASE) ? S_REL : S_GRP;
        end
      end
      S_GRP: begin
        cmd.find_grp = 1'b1;
        state_nxt    = S_BIT;
      end
      S_BIT: begin
        cmd.alloc = 1'b1;
        state_nxt = S_FIN;
      end
      S_REL: begin
        cmd.release_chk = 1'b1;
        state_nxt       = sts.rel_top ? S_WALK : S_FIN;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (!sts.walk_more) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.push) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> design/lfia_datapath.sv
// Datapath holding the high-water mark, vacant map, two-level search and result registers.
module lfia_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            in_release_id,
  input  lfia_pkg::lfia_cmd_t   cmd,
  output lfia_pkg::lfia_sts_t   sts,
  output logic [7:0]            out_granted_id,
  output logic [1:0]            out_outcome
);
  import lfia_pkg::*;

  logic [MAP_DEPTH-1:0] vac_r, vac_nxt;
  logic [HW_W-1:0]      hw_r, hw_nxt;
  logic [ID_W-1:0]      rid_r;
  logic [GRP_W-1:0]     grp_r, grp_nxt;
  logic                 any_r, any_nxt;
  logic [ID_W-1:0]      res_id_r, res_id_nxt;
  logic [1:0]           res_code_r, res_code_nxt;
  logic [ID_W-1:0]      out_id_r;
  logic [1:0]           out_code_r;

  logic [GRP_N-1:0]     summary;
  logic [BIT_N-1:0]     grp_bits;
  logic [BIT_W-1:0]     bit_idx;
  logic [GRP_W-1:0]     grp_idx;
  logic [HW_W-1:0]      hw_dec;
  logic [HW_W-1:0]      rid_ext;
  logic                 rel_bad;

  function automatic logic [3:0] lowest16(input logic [15:0] v);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

  always_comb begin
    for (int g = 0; g < GRP_N; g++) begin
      summary[g] = |vac_r[g*BIT_N +: BIT_N];
    end
  end

  assign grp_idx  = lowest16(summary);
  assign grp_bits = vac_r[grp_r*BIT_N +: BIT_N];
  assign bit_idx  = lowest16(grp_bits);
  assign hw_dec   = hw_r - HW_W'(1);
  assign rid_ext  = {1'b0, rid_r};
  assign rel_bad  = (rid_ext >= hw_r) || vac_r[rid_r];

  assign sts.rel_top   = !rel_bad && ((rid_ext + HW_W'(1)) == hw_r);
  assign sts.walk_more = (hw_r != '0) && vac_r[hw_dec[ID_W-1:0]];

  always_comb begin
    vac_nxt      = vac_r;
    hw_nxt       = hw_r;
    grp_nxt      = grp_r;
    any_nxt      = any_r;
    res_id_nxt   = res_id_r;
    res_code_nxt = res_code_r;
    priority if (cmd.find_grp) begin
      grp_nxt = grp_idx;
      any_nxt = |summary;
    end else if (cmd.alloc) begin
      if (any_r) begin
        vac_nxt[{grp_r, bit_idx}] = 1'b0;
        res_id_nxt                = {grp_r, bit_idx};
        res_code_nxt              = OUT_GRANTED;
      end else if (hw_r >= ID_LIMIT) begin
        res_id_nxt   = '0;
        res_code_nxt = OUT_EXHAUSTED;
      end else begin
        res_id_nxt   = hw_r[ID_W-1:0];
        res_code_nxt = OUT_GRANTED;
        hw_nxt       = hw_r + HW_W'(1);
      end
    end else if (cmd.release_chk) begin
      res_id_nxt = '0;
      if (rel_bad) begin
        res_code_nxt = OUT_INVALID;
      end else if (sts.rel_top) begin
        res_code_nxt = OUT_RELEASED;
        hw_nxt       = rid_ext;
      end else begin
        res_code_nxt   = OUT_RELEASED;
        vac_nxt[rid_r] = 1'b1;
      end
    end else if (cmd.walk) begin
      if (sts.walk_more) begin
        vac_nxt[hw_dec[ID_W-1:0]] = 1'b0;
        hw_nxt                    = hw_dec;
      end
    end else begin
      hw_nxt = hw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vac_r <= '0;
      hw_r  <= '0;
    end else begin
      vac_r <= vac_nxt;
      hw_r  <= hw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_r      <= grp_nxt;
    any_r      <= any_nxt;
    res_id_r   <= res_id_nxt;
    res_code_r <= res_code_nxt;
    if (cmd.load) begin
      rid_r <= in_release_id;
    end
    if (cmd.push) begin
      out_id_r   <= res_id_r;
      out_code_r <= res_code_r;
    end
  end

  assign out_granted_id = out_id_r;
  assign out_outcome    = out_code_r;

endmodule

>>> design/lowest_free_id_allocator_unit.sv
// Top level of the lowest-free ID allocator: controller, datapath and checks.
//
//   Channel  Direction  tdata              tuser
//   in_      slave      [7:0] release_id   [0] mode
//   out_     master     [7:0] granted_id   [1:0] outcome
//
// An allocate passes through acceptance, the group search, the bit search within the
// group and the hand-off; its result word is loaded into the output register at the
// hand-off, and the next word is accepted only after the hand-off.
// A release passes through acceptance, the release check and the hand-off; a release of
// the top ID also walks the mark down past vacant IDs, one map entry per cycle.
// Synchronous active-low reset clears the mark and the whole vacant map at once.
// A result word waits in the output register; the next word is accepted meanwhile,
// and the block stalls only when a second result is ready before the first is taken.
module lowest_free_id_allocator_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] release_id
  input  logic [0:0] in_tuser,   // [0] mode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] granted_id
  output logic [1:0] out_tuser   // [1:0] outcome
);
  import lfia_pkg::*;

  lfia_cmd_t cmd;
  lfia_sts_t sts;

  lfia_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (in_tuser[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  lfia_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_release_id  (in_tdata),
    .cmd            (cmd),
    .sts            (sts),
    .out_granted_id (out_tdata),
    .out_outcome    (out_tuser)
  );

`ifndef SYNTHESIS
  a_nongrant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != OUT_GRANTED) |-> out_tdata == '0)
    else $error("non-grant result carries a nonzero ID");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("block ready again right after accepting a word");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.find_grp, cmd.alloc, cmd.release_chk, cmd.walk, cmd.push}))
    else $error("more than one datapath command at once");

  a_push_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> out_tvalid)
    else $error("result pushed but output not valid");
`endif

endmodule

>>> verif/lowest_free_id_allocator_unit_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the ID allocator that predicts every result word and compares it field by field.
module lowest_free_id_allocator_unit_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  input  logic [7:0]                    in_tdata,
  input  logic [0:0]                    in_tuser,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [7:0]                    out_tdata,
  input  logic [1:0]                    out_tuser,
  output int                            mismatches,
  output int                            outstanding,
  output logic [lfia_pkg::HW_W-1:0]      mark_view,
  output logic [lfia_pkg::MAP_DEPTH-1:0] vacant_view
);
  import lfia_pkg::*;

  typedef struct {
    logic [ID_W-1:0] granted_id;
    logic [1:0]      outcome;
  } grant_result_t;

  logic [HW_W-1:0]      high_mark = '0;
  logic [MAP_DEPTH-1:0] vacant_ids = '0;
  grant_result_t        awaited_results[$];
  int                   fault_count = 0;

  task automatic report_mismatch(input string msg);
    if (fault_count < 100) begin
      $display("%0t ns: %s", $time, msg);
    end
    fault_count++;
  endtask

  task automatic predict_grant(input logic mode, input logic [ID_W-1:0] id,
                               output logic [ID_W-1:0] granted, output logic [1:0] code);
    int   i;
    logic found;
    granted = '0;
    found   = 1'b0;
    if (mode != MODE_RELEASE) begin
      for (i = 0; i < MAP_DEPTH && !found; i++) begin
        if (i < high_mark && vacant_ids[i]) begin
          vacant_ids[i] = 1'b0;
          granted       = ID_W'(i);
          code          = OUT_GRANTED;
          found         = 1'b1;
        end
      end
      if (!found) begin
        if (high_mark >= ID_LIMIT) begin
          code = OUT_EXHAUSTED;
        end else begin
          granted   = high_mark[ID_W-1:0];
          code      = OUT_GRANTED;
          high_mark = high_mark + 1'b1;
        end
      end
    end else if ({1'b0, id} >= high_mark || vacant_ids[id]) begin
      code = OUT_INVALID;
    end else begin
      if ({1'b0, id} + 9'd1 == high_mark) begin
        high_mark = high_mark - 1'b1;
        while (high_mark != 0 && vacant_ids[high_mark - 9'd1]) begin
          vacant_ids[high_mark - 9'd1] = 1'b0;
          high_mark = high_mark - 1'b1;
        end
      end else begin
        vacant_ids[id] = 1'b1;
      end
      code = OUT_RELEASED;
    end
  endtask

  always @(posedge clk) begin
    grant_result_t want;
    grant_result_t fresh;
    if (!rst_n) begin
      high_mark  = '0;
      vacant_ids = '0;
      awaited_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result word with none expected: granted_id %0d outcome %0d",
                                    out_tdata, out_tuser));
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata !== want.granted_id) begin
            report_mismatch($sformatf("granted_id mismatch: got %0d, expected %0d",
                                      out_tdata, want.granted_id));
          end
          if (out_tuser !== want.outcome) begin
            report_mismatch($sformatf("outcome mismatch: got %0d, expected %0d",
                                      out_tuser, want.outcome));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        predict_grant(in_tuser[0], in_tdata, fresh.granted_id, fresh.outcome);
        awaited_results.insert(awaited_results.size(), fresh);
      end
    end
    mismatches  <= fault_count;
    outstanding <= awaited_results.size();
    mark_view   <= high_mark;
    vacant_view <= vacant_ids;
  end

endmodule

>>> verif/lowest_free_id_allocator_unit_test.sv
`timescale 1ns / 1ps
// Test top for the ID allocator that drives request words, stalls the receiver and gives the verdict.
module lowest_free_id_allocator_unit_test;
  import lfia_pkg::*;

  localparam int   IDLE_LIMIT    = 3000;
  localparam int   HOLD_CYCLES   = 400;
  localparam logic MODE_ALLOCATE = ~MODE_RELEASE;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [7:0]           in_tdata = '0;  // [7:0] release_id
  logic [0:0]           in_tuser = '0;  // [0] mode
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;      // [7:0] granted_id
  logic [1:0]           out_tuser;      // [1:0] outcome
  int                   mismatches;
  int                   outstanding;
  logic [HW_W-1:0]      mark_view;
  logic [MAP_DEPTH-1:0] vacant_view;
  logic                 hold_req = 1'b0;
  logic                 hold_done = 1'b0;
  int                   hold_left = 0;
  int                   stall_style = 0;
  int                   style_left = 0;
  int                   burst_left = 0;
  int                   idle_cycles = 0;

  always #6 clk = ~clk;

  lowest_free_id_allocator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  lowest_free_id_allocator_unit_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .mark_view  (mark_view),
    .vacant_view(vacant_view)
  );

  task automatic send_word(input logic mode, input logic [ID_W-1:0] id);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 32);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= id;
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic wait_drained();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [ID_W-1:0] pick_release_id();
    logic [ID_W-1:0] id;
    int              tries;
    if (mark_view == 0) begin
      return ID_W'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 3) == 0) begin
      return ID_W'(mark_view - 9'd1);
    end
    id = ID_W'($urandom_range(0, mark_view - 1));
    for (tries = 0; tries < 8 && vacant_view[id]; tries++) begin
      id = ID_W'($urandom_range(0, mark_view - 1));
    end
    return id;
  endfunction

  task automatic send_random(input int alloc_pct);
    if ($urandom_range(0, 99) < 12) begin
      send_word(1'($urandom_range(0, 1)), ID_W'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 99) < alloc_pct) begin
      send_word(MODE_ALLOCATE, ID_W'($urandom_range(0, 255)));
    end else begin
      send_word(MODE_RELEASE, pick_release_id());
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style <= $urandom_range(0, 2);
        style_left  <= $urandom_range(16, 128);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        0: begin
          out_tready <= 1'b1;
        end
        1: begin
          out_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          out_tready <= ($urandom_range(0, 7) != 0);
        end
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("lowest_free_id_allocator_unit_test: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Releases against an empty pool, then a short pool with vacant IDs and walk-downs.
    send_word(MODE_RELEASE, 8'h00);
    send_word(MODE_RELEASE, 8'hFF);
    send_word(MODE_ALLOCATE, 8'hFF);
    send_word(MODE_ALLOCATE, 8'h00);
    send_word(MODE_ALLOCATE, 8'h55);
    send_word(MODE_ALLOCATE, 8'hAA);
    send_word(MODE_RELEASE, 8'h01);
    send_word(MODE_RELEASE, 8'h01);
    send_word(MODE_RELEASE, 8'h04);
    send_word(MODE_RELEASE, 8'h02);
    send_word(MODE_RELEASE, 8'h03);
    send_word(MODE_ALLOCATE, 8'h00);
    send_word(MODE_ALLOCATE, 8'h00);
    send_word(MODE_RELEASE, 8'h00);
    send_word(MODE_ALLOCATE, 8'h00);
    send_word(MODE_RELEASE, 8'h02);
    send_word(MODE_RELEASE, 8'h01);
    send_word(MODE_RELEASE, 8'h00);
    send_word(MODE_RELEASE, 8'h00);

    // Fill the whole ID space and run into exhaustion.
    for (n = 0; n < 262; n++) begin
      send_word(MODE_ALLOCATE, ID_W'($urandom));
    end
    send_word(MODE_RELEASE, 8'h80);
    send_word(MODE_RELEASE, 8'hFF);
    send_word(MODE_ALLOCATE, 8'h00);
    send_word(MODE_ALLOCATE, 8'h00);
    send_word(MODE_ALLOCATE, 8'h00);
    wait_drained();

    for (n = 0; n < 200; n++) begin
      send_random(10);
    end
    for (n = 0; n < 900; n++) begin
      if (n == 300) begin
        hold_req <= 1'b1;
      end
      send_random(((n / 150) % 2 != 0) ? 70 : 35);
    end
    for (n = 0; n < 150; n++) begin
      send_random(20);
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("lowest_free_id_allocator_unit_test: clean");
    end else begin
      $display("lowest_free_id_allocator_unit_test: errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/lfia_pkg.sv
design/lfia_ctrl.sv
design/lfia_datapath.sv
design/lowest_free_id_allocator_unit.sv
verif/lowest_free_id_allocator_unit_checker.sv
verif/lowest_free_id_allocator_unit_test.sv
